// ----- hdl/dttv_pkg.sv -----
// ----------------------------------------------------------------------------
// dttv_pkg
// Shared types, character codes, field positions and helper functions for the
// date-time text validator.
// ----------------------------------------------------------------------------
package dttv_pkg;

   typedef logic [4:0] pos_type;
   typedef logic [6:0] acc_type;
   typedef logic [4:0] mlen_type;

   // Character codes.
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_COLON = 8'd58;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;

   // Character positions in the text.
   localparam pos_type POS_DAY_HI   = 5'd0;
   localparam pos_type POS_DAY_LO   = 5'd1;
   localparam pos_type POS_SEP_DM   = 5'd2;
   localparam pos_type POS_MON_HI   = 5'd3;
   localparam pos_type POS_MON_LO   = 5'd4;
   localparam pos_type POS_SEP_MY   = 5'd5;
   localparam pos_type POS_YEAR_0   = 5'd6;
   localparam pos_type POS_YEAR_1   = 5'd7;
   localparam pos_type POS_YEAR_2   = 5'd8;
   localparam pos_type POS_YEAR_3   = 5'd9;
   localparam pos_type POS_BLANK    = 5'd10;
   localparam pos_type POS_HOUR_A   = 5'd11;
   localparam pos_type POS_HOUR_B   = 5'd12;
   localparam pos_type POS_SEP_HM   = 5'd13;
   localparam pos_type POS_MIN_HI   = 5'd14;
   localparam pos_type POS_MIN_LO   = 5'd15;
   localparam pos_type POS_SEP_MS   = 5'd16;
   localparam pos_type POS_SEC_HI   = 5'd17;
   localparam pos_type POS_SEC_LO   = 5'd18;
   localparam pos_type POS_SAT      = 5'd31;

   // Field limits.
   localparam acc_type MAX_HOUR     = 7'd23;
   localparam acc_type MAX_MIN_SEC  = 7'd59;
   localparam acc_type MAX_MONTH    = 7'd12;
   localparam acc_type MIN_CENTURY  = 7'd19;
   localparam acc_type MIN_YEAR_LO  = 7'd80;

   localparam acc_type MONTH_FEB    = 7'd2;
   localparam acc_type MONTH_APR    = 7'd4;
   localparam acc_type MONTH_JUN    = 7'd6;
   localparam acc_type MONTH_SEP    = 7'd9;
   localparam acc_type MONTH_NOV    = 7'd11;

   // Decimal accumulate: v * 10 + digit, kept to seven bits.
   function automatic acc_type acc_digit(input acc_type v, input logic [3:0] d);
      return (v << 3) + (v << 1) + {3'b000, d};
   endfunction

   function automatic mlen_type month_len(input acc_type m, input logic leap);
      mlen_type len;
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         len = 5'd30;
      end else if (m == MONTH_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

endpackage

// ----- hdl/date_time_text_validator.sv -----
// ----------------------------------------------------------------------------
// date_time_text_validator
// Checks a character stream for the form DD:MM:YYYY<ws>HH:MM:SS and gives
// one verdict item on the last character of each text.
// A text's last character passes the input register and the snapshot; its verdict is then registered.
// Throughput: one character item per cycle; only the last one yields a result.
// The whole pipeline advances together and holds while a result is stalled.
// Reset is synchronous and active high; it empties all stages and returns the
// scanner to the first character position.
// ----------------------------------------------------------------------------
module date_time_text_validator
   import dttv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_char,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res
);

   // The pipeline has three registered stages: the input register, the scan
   // state together with a snapshot taken on the last character, and the
   // result register. They all move on one shared enable, which is false
   // only while a finished verdict waits to be taken.
   logic advance;

   // Input register.
   logic       in_vld_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // Scan state. The year is kept as century and year-in-century digit pairs
   // so that the leap-year test needs no division.
   pos_type pos_ff,        pos_in;
   logic    good_ff,       good_in;
   logic    hour_begun_ff, hour_begun_in;
   acc_type day_ff,       day_in;
   acc_type month_ff,     month_in;
   acc_type yhi_ff,       yhi_in;
   acc_type ylo_ff,       ylo_in;
   acc_type hour_ff,      hour_in;
   acc_type min_ff,       min_in;
   acc_type sec_ff,       sec_in;

   // Values after the current character has been applied.
   logic    upd_good;
   logic    upd_begun;
   acc_type upd_day, upd_month, upd_yhi, upd_ylo, upd_hour, upd_min, upd_sec;

   // Snapshot of a finished text, checked in the next stage.
   logic    chk_vld_ff;
   logic    chk_good_ff;
   acc_type chk_day_ff, chk_month_ff, chk_yhi_ff, chk_ylo_ff;
   acc_type chk_hour_ff, chk_min_ff, chk_sec_ff;

   // Result register.
   logic rsp_vld_ff;
   logic rsp_res_ff, rsp_res_in;

   logic       is_digit;
   logic       is_blank;
   logic       char_ok;
   logic [3:0] digit;
   logic       leap;
   logic       year_ok;

   assign advance   = !(rsp_vld_ff && rsp_stall);
   assign req_stall = !advance;

   // Input register: takes an item whenever the pipeline moves.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (advance) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_char_ff <= req_text_char;
         in_last_ff <= req_is_last;
      end
   end

   // Character classes. Whitespace is space and the control codes from tab
   // to carriage return.
   assign is_digit = (in_char_ff >= CHAR_ZERO) && (in_char_ff <= CHAR_NINE);
   assign is_blank = (in_char_ff == CHAR_SPACE) ||
                     ((in_char_ff >= CHAR_TAB) && (in_char_ff <= CHAR_CR));
   assign digit    = in_char_ff[3:0];

   // Per-position check and decimal accumulation.
   always_comb begin
      char_ok   = 1'b1;
      upd_begun = hour_begun_ff;
      upd_day   = day_ff;
      upd_month = month_ff;
      upd_yhi   = yhi_ff;
      upd_ylo   = ylo_ff;
      upd_hour  = hour_ff;
      upd_min   = min_ff;
      upd_sec   = sec_ff;
      unique case (pos_ff)
         POS_DAY_HI, POS_DAY_LO: begin
            if (is_digit) upd_day = acc_digit(day_ff, digit);
            else          char_ok = 1'b0;
         end
         POS_MON_HI, POS_MON_LO: begin
            if (is_digit) upd_month = acc_digit(month_ff, digit);
            else          char_ok = 1'b0;
         end
         POS_YEAR_0, POS_YEAR_1: begin
            if (is_digit) upd_yhi = acc_digit(yhi_ff, digit);
            else          char_ok = 1'b0;
         end
         POS_YEAR_2, POS_YEAR_3: begin
            if (is_digit) upd_ylo = acc_digit(ylo_ff, digit);
            else          char_ok = 1'b0;
         end
         POS_SEP_DM, POS_SEP_MY, POS_SEP_HM, POS_SEP_MS: begin
            char_ok = (in_char_ff == CHAR_COLON);
         end
         POS_BLANK: begin
            char_ok = is_blank;
         end
         POS_HOUR_A: begin
            // A second blank is allowed here as long as no hour digit came.
            if (is_digit) begin
               upd_hour  = acc_digit(hour_ff, digit);
               upd_begun = 1'b1;
            end else begin
               char_ok = is_blank && !hour_begun_ff;
            end
         end
         POS_HOUR_B: begin
            if (is_digit) begin
               upd_hour  = acc_digit(hour_ff, digit);
               upd_begun = 1'b1;
            end else begin
               char_ok = 1'b0;
            end
         end
         POS_MIN_HI, POS_MIN_LO: begin
            if (is_digit) upd_min = acc_digit(min_ff, digit);
            else          char_ok = 1'b0;
         end
         POS_SEC_HI, POS_SEC_LO: begin
            if (is_digit) upd_sec = acc_digit(sec_ff, digit);
            else          char_ok = 1'b0;
         end
         default: begin
            // Any character beyond the expected length breaks the format.
            char_ok = 1'b0;
         end
      endcase
      upd_good = good_ff && char_ok;
   end

   // Next scan state: the last character of a text returns everything to the
   // start position.
   always_comb begin
      pos_in        = pos_ff;
      good_in       = good_ff;
      hour_begun_in = hour_begun_ff;
      day_in        = day_ff;
      month_in      = month_ff;
      yhi_in        = yhi_ff;
      ylo_in        = ylo_ff;
      hour_in       = hour_ff;
      min_in        = min_ff;
      sec_in        = sec_ff;
      if (in_vld_ff) begin
         if (in_last_ff) begin
            pos_in        = '0;
            good_in       = 1'b1;
            hour_begun_in = 1'b0;
            day_in        = '0;
            month_in      = '0;
            yhi_in        = '0;
            ylo_in        = '0;
            hour_in       = '0;
            min_in        = '0;
            sec_in        = '0;
         end else begin
            pos_in        = (pos_ff == POS_SAT) ? pos_ff : pos_ff + 5'd1;
            good_in       = upd_good;
            hour_begun_in = upd_begun;
            day_in        = upd_day;
            month_in      = upd_month;
            yhi_in        = upd_yhi;
            ylo_in        = upd_ylo;
            hour_in       = upd_hour;
            min_in        = upd_min;
            sec_in        = upd_sec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         good_ff       <= 1'b1;
         hour_begun_ff <= 1'b0;
         day_ff        <= '0;
         month_ff      <= '0;
         yhi_ff        <= '0;
         ylo_ff        <= '0;
         hour_ff       <= '0;
         min_ff        <= '0;
         sec_ff        <= '0;
         chk_vld_ff    <= 1'b0;
      end else if (advance) begin
         pos_ff        <= pos_in;
         good_ff       <= good_in;
         hour_begun_ff <= hour_begun_in;
         day_ff        <= day_in;
         month_ff      <= month_in;
         yhi_ff        <= yhi_in;
         ylo_ff        <= ylo_in;
         hour_ff       <= hour_in;
         min_ff        <= min_in;
         sec_ff        <= sec_in;
         chk_vld_ff    <= in_vld_ff && in_last_ff;
      end
   end

   // Snapshot of the completed fields. The text only counts when its last
   // character sits at the final position.
   always_ff @(posedge clock) begin
      if (advance) begin
         chk_good_ff  <= upd_good && (pos_ff == POS_SEC_LO);
         chk_day_ff   <= upd_day;
         chk_month_ff <= upd_month;
         chk_yhi_ff   <= upd_yhi;
         chk_ylo_ff   <= upd_ylo;
         chk_hour_ff  <= upd_hour;
         chk_min_ff   <= upd_min;
         chk_sec_ff   <= upd_sec;
      end
   end

   // Range checks. With a good format the year has exactly four digits, so
   // a century divisible by four decides a century year, and otherwise the
   // last two digits decide.
   assign leap    = (chk_ylo_ff == '0) ? (chk_yhi_ff[1:0] == 2'b00)
                                       : (chk_ylo_ff[1:0] == 2'b00);
   assign year_ok = (chk_yhi_ff > MIN_CENTURY) ||
                    ((chk_yhi_ff == MIN_CENTURY) && (chk_ylo_ff >= MIN_YEAR_LO));

   assign rsp_res_in = chk_good_ff &&
                       (chk_hour_ff <= MAX_HOUR) &&
                       (chk_min_ff  <= MAX_MIN_SEC) &&
                       (chk_sec_ff  <= MAX_MIN_SEC) &&
                       year_ok &&
                       (chk_month_ff != '0) && (chk_month_ff <= MAX_MONTH) &&
                       (chk_day_ff != '0) &&
                       (chk_day_ff <= {2'b00, month_len(chk_month_ff, leap)});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= chk_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_res_ff <= rsp_res_in;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_valid_res = rsp_res_ff;

endmodule

// ----- hdl/dttv_checker.sv -----
// ----------------------------------------------------------------------------
// dttv_checker
// Port-level checks for the date-time text validator, bound to the top level.
// ----------------------------------------------------------------------------
module dttv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_is_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_valid_res
);

   // A stalled result holds its verdict.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res))
      else $error("stalled result changed");

   // The input side only stalls behind a waiting, stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // Reset leaves the pipeline empty and open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // A character that is not the last of its text never becomes a result.
   // While the result side stays empty the pipeline does not stall, so that
   // character would pass the input register and the snapshot to the result port.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_is_last ##1 !rsp_valid ##1 !rsp_valid
      |=> !rsp_valid)
      else $error("result without a last character");

endmodule

bind date_time_text_validator dttv_checker u_dttv_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_is_last   (req_is_last),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_valid_res (rsp_valid_res)
);
